// ----- hw/rtl/b2da_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// shared widths, constants and control types of the binary to decimal text
// converter
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int IN_BITS     = 32;
  localparam int CHAR_BITS   = 6;
  localparam int NUM_DIGITS  = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCD_BITS    = NUM_DIGITS * 4;
  localparam int BITCNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int REM_BITS    = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);
  localparam logic [3:0]           ADJ_LIMIT  = 4'd5;
  localparam logic [3:0]           ADJ_ADD    = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SEND
  } b2da_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } b2da_cmd_t;

  typedef struct packed {
    logic bit_last;
    logic top_zero;
    logic rem_one;
  } b2da_sts_t;

endpackage

// ----- hw/rtl/b2da_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_if
// handshake channels: binary number in, decimal characters out
// ----------------------------------------------------------------------------
interface b2da_num_if
  import b2da_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_char_if
  import b2da_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] digit_char;
  logic                 last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- hw/rtl/b2da_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_ctrl
// sequencer: load, shift-add-3 steps, leading zero skip, digit send
// ----------------------------------------------------------------------------
module b2da_ctrl
  import b2da_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output b2da_cmd_t cmd,
  input  b2da_sts_t sts
);

  b2da_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (sts.bit_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.top_zero && !sts.rem_one) begin
          cmd.shift = 1'b1;
        end else begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.shift = 1'b1;
          if (sts.rem_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/b2da_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_dpath
// binary shift register, bcd digit register with add-3 correction, counters
// ----------------------------------------------------------------------------
module b2da_dpath
  import b2da_pkg::*;
(
  input  logic                 clk,
  input  logic [IN_BITS-1:0]   value,
  input  b2da_cmd_t            cmd,
  output b2da_sts_t            sts,
  output logic [CHAR_BITS-1:0] digit_char,
  output logic                 last_digit
);

  logic [VALUE_BITS-1:0]  bin;
  logic [BCD_BITS-1:0]    bcd;
  logic [BCD_BITS-1:0]    bcd_adj;
  logic [BITCNT_BITS-1:0] bitcnt;
  logic [REM_BITS-1:0]    rem;
  logic [3:0]             top;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= ADJ_LIMIT) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + ADJ_ADD;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin    <= VALUE_BITS'(value);
      bcd    <= '0;
      bitcnt <= BITCNT_BITS'(VALUE_BITS - 1);
      rem    <= REM_BITS'(NUM_DIGITS);
    end else if (cmd.step) begin
      bin    <= bin << 1;
      bcd    <= {bcd_adj[BCD_BITS-2:0], bin[VALUE_BITS-1]};
      bitcnt <= bitcnt - 1'b1;
    end else if (cmd.shift) begin
      bcd <= bcd << 4;
      rem <= rem - 1'b1;
    end
  end

  assign top          = bcd[BCD_BITS-1 -: 4];
  assign sts.bit_last = (bitcnt == '0);
  assign sts.top_zero = (top == 4'd0);
  assign sts.rem_one  = (rem == REM_BITS'(1));
  assign digit_char   = ASCII_ZERO + CHAR_BITS'(top);
  assign last_digit   = sts.rem_one;

endmodule

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// unsigned binary number to decimal ascii digits, most significant first
// ----------------------------------------------------------------------------
// One number is taken at a time. After the input beat the shift-add-3 datapath
// runs one step per cycle, a step for each of the VALUE_BITS input bits, then
// drops leading zero digits at one per cycle (up to 9) before it finds the first
// digit, then sends each digit as one output beat, the final digit flagged by
// last_digit; a zero gives a single '0'. The conversion is one bit-serial loop.
// The next number is accepted once the last digit beat has been taken.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  b2da_num_if.sink    number,
  b2da_char_if.source text
);

  b2da_cmd_t cmd;
  b2da_sts_t sts;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  b2da_dpath u_dpath (
    .clk        (clk),
    .value      (number.value),
    .cmd        (cmd),
    .sts        (sts),
    .digit_char (text.digit_char),
    .last_digit (text.last_digit)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives unsigned numbers into binary_to_decimal_ascii and checks every digit
// beat against a behavioral decimal conversion, under four idling phases, a
// long output hold-off and a full drain between phases
// ----------------------------------------------------------------------------
module testbench;
  import b2da_pkg::*;

  localparam int          CLK_HALF     = 6;
  localparam int          RESET_CYCLES = 6;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          TAIL_CYCLES  = 60;
  localparam int          MAX_PRINTS   = 30;
  localparam int unsigned DEC_BASE     = 10;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } digit_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b2da_num_if  num_ch ();
  b2da_char_if txt_ch ();

  binary_to_decimal_ascii dut (
    .clk    (clk),
    .rst    (rst),
    .number (num_ch),
    .text   (txt_ch)
  );

  logic [IN_BITS-1:0] pending_numbers [$];
  digit_beat_t        digits_due [$];

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic rx_hold        = 1'b0;
  logic number_taken   = 1'b0;
  int   fail_count     = 0;
  int   numbers_sent   = 0;
  int   digits_checked = 0;
  event hold_start;

  always #CLK_HALF clk = ~clk;

  task automatic report(input string msg);
    if (fail_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // decimal digits of one number, most significant first, final one marked
  function automatic void predict_digits(input logic [IN_BITS-1:0] value);
    logic [63:0] n;
    logic [3:0]  dig [20];
    int          cnt;
    digit_beat_t beat;
    n = 64'(value);
    if (VALUE_BITS < 64) begin
      n = n & ((64'd1 << VALUE_BITS) - 64'd1);
    end
    cnt = 0;
    dig[cnt] = 4'(n % DEC_BASE);
    n = n / DEC_BASE;
    cnt++;
    while (n != 0 && cnt < 20) begin
      dig[cnt] = 4'(n % DEC_BASE);
      n = n / DEC_BASE;
      cnt++;
    end
    for (int k = cnt - 1; k >= 0; k--) begin
      beat.digit_char = ASCII_ZERO + CHAR_BITS'(dig[k]);
      beat.last_digit = (k == 0);
      digits_due.push_back(beat);
    end
  endfunction

  function automatic logic [IN_BITS-1:0] random_number();
    longint unsigned pow10 [11];
    longint unsigned lo;
    longint unsigned hi;
    int              pick;
    int              len;
    pow10[0] = 1;
    for (int k = 1; k < 11; k++) begin
      pow10[k] = pow10[k-1] * DEC_BASE;
    end
    pick = $urandom_range(9);
    if (pick < 3) begin
      return $urandom();
    end else if (pick < 6) begin
      len = $urandom_range(1, 10);
      lo  = (len == 1) ? 0 : pow10[len-1];
      hi  = (len == 10) ? 64'hFFFF_FFFF : pow10[len] - 1;
      return IN_BITS'(lo + $urandom_range(32'(hi - lo)));
    end else if (pick < 8) begin
      return IN_BITS'(pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1);
    end else if (pick < 9) begin
      return $urandom_range(0, 99);
    end else begin
      return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    end
  endfunction

  // sender pause: wait until nothing is queued, offered or expected
  task automatic drain();
    while (pending_numbers.size() != 0 || num_ch.valid || digits_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(hold_start) begin
    rx_hold = 1'b1;
    for (int k = 0; k < HOLD_CYCLES; k++) begin
      @(posedge clk);
    end
    rx_hold = 1'b0;
  end

  // number driver
  always @(negedge clk) begin
    if (rst) begin
      num_ch.valid <= 1'b0;
    end else if (!num_ch.valid || number_taken) begin
      if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        num_ch.valid <= 1'b1;
        num_ch.value <= pending_numbers.pop_front();
      end else begin
        num_ch.valid <= 1'b0;
      end
    end
  end

  // digit receiver
  always @(negedge clk) begin
    txt_ch.ready <= !rst && !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on each number beat, check each digit beat
  always @(posedge clk) begin
    digit_beat_t want;
    number_taken = 1'b0;
    if (!rst) begin
      if (num_ch.valid && num_ch.ready) begin
        number_taken = 1'b1;
        numbers_sent++;
        predict_digits(num_ch.value);
      end
      if (txt_ch.valid && txt_ch.ready) begin
        digits_checked++;
        if (digits_due.size() == 0) begin
          report($sformatf("digit beat 0x%0h last %0b with none expected",
                           txt_ch.digit_char, txt_ch.last_digit));
        end else begin
          want = digits_due.pop_front();
          if (txt_ch.digit_char !== want.digit_char) begin
            report($sformatf("digit_char 0x%0h, expected 0x%0h",
                             txt_ch.digit_char, want.digit_char));
          end
          if (txt_ch.last_digit !== want.last_digit) begin
            report($sformatf("last_digit %0b, expected %0b",
                             txt_ch.last_digit, want.last_digit));
          end
        end
      end
    end
  end

  initial begin
    logic [IN_BITS-1:0] directed [$];
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd42,
                 32'd12345, 32'd987654321, 32'd999999999, 32'd1000000000,
                 32'd1000000001, 32'd1234567890, 32'd2147483647, 32'd2147483648,
                 32'd4000000000, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4294967294,
                 32'd4294967295};
    num_ch.valid = 1'b0;
    num_ch.value = '0;
    txt_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_numbers = directed;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          -> hold_start;
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pending_numbers.push_back(random_number());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    while (digits_due.size() != 0) begin
      report($sformatf("digit 0x%0h never arrived", digits_due.pop_front().digit_char));
    end

    $display("converted %0d numbers into %0d checked digit beats", numbers_sent,
             digits_checked);
    $display("phases: free flow with long output hold-off, slow sender, slow receiver, light jitter");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
